// ===== hdl/mbg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_pkg
// Shared types and constants of the maze backtracker generator.
// ----------------------------------------------------------------------------
package mbg_pkg;

  // Grid size defaults.
  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 32;

  // Width of an effective dimension (covers 1..256 and the 6-bit register).
  localparam int DIMW = 9;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 6'd32;

  // Input modes.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_IDLE  = 2'd3;

  // Result actions.
  localparam logic [2:0] ACT_STARTED = 3'd0;
  localparam logic [2:0] ACT_CARVED  = 3'd1;
  localparam logic [2:0] ACT_BACK    = 3'd2;
  localparam logic [2:0] ACT_IDLE    = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;

  // Directions.
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Cell bit encoding.
  localparam logic [4:0] BIT_VIS = 5'b00001;
  localparam logic [4:0] BIT_N   = 5'b00010;
  localparam logic [4:0] BIT_E   = 5'b00100;
  localparam logic [4:0] BIT_S   = 5'b01000;
  localparam logic [4:0] BIT_W   = 5'b10000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  coord_x;
    logic [4:0]  coord_y;
    logic [14:0] rand_value;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [4:0]  pos_x;
    logic [4:0]  pos_y;
    logic [1:0]  direction;
    logic [4:0]  cell_bits;
    logic [4:0]  end_x;
    logic [4:0]  end_y;
    logic [10:0] longest_path;
    logic        done_res;
  } out_t;

  // Neighbor choice from the pick unit.
  typedef struct packed {
    logic       found;
    logic [1:0] dir;
  } pick_t;

endpackage
`default_nettype wire

// ===== hdl/maze_backtracker_generator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maze_backtracker_generator_top
// Depth-first maze carving over a cell memory and a coordinate stack memory.
//
//   channel | signals                        | moves
//   --------+--------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_word    | one command word
//   out     | out_valid, out_ready, out_word | one result word per command
//   cfg     | cfg_we, cfg_index, cfg_wdata   | width / height register write
//
// One command at a time. A step reads the stack top and its four neighbors
// through the single read port, chooses, then makes a carve write, or a stack
// read and a cell fetch when backing up. A read or idle command either
// fetches the cell bits or answers at once. A start sweeps the whole cell
// memory, then folds the start cell into the grid and writes it.
// After reset the same sweep runs before the first command is taken.
// A stalled result holds the output register; the next command is accepted
// meanwhile and waits in its last state for the register to free up.
// ----------------------------------------------------------------------------
module maze_backtracker_generator_top #(
  parameter int MAX_WIDTH  = mbg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mbg_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire mbg_pkg::in_t                    in_word,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mbg_pkg::out_t                        out_word,
  input  wire logic                            cfg_we,
  input  wire logic [mbg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mbg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int DW    = mbg_pkg::DIMW;
  localparam int PW    = 2 * DW;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_MOD    = 10'b0000000100,
    ST_NB     = 10'b0000001000,
    ST_EVAL   = 10'b0000010000,
    ST_CARVE  = 10'b0000100000,
    ST_POP    = 10'b0001000000,
    ST_FETCH  = 10'b0010000000,
    ST_FETCH2 = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [mbg_pkg::CFG_DATA_W-1:0] width_in_use;
  logic [mbg_pkg::CFG_DATA_W-1:0] height_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= mbg_pkg::SIZE_RESET;
      height_in_use <= mbg_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mbg_pkg::CFG_WIDTH:  width_in_use  <= cfg_wdata;
        mbg_pkg::CFG_HEIGHT: height_in_use <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective size, clamped to 1..MAX.
  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;
  logic [PW-1:0] wh;

  always_comb begin
    if (width_in_use == '0) begin
      w_eff = DW'(1);
    end else if (DW'(width_in_use) > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(width_in_use);
    end
    if (height_in_use == '0) begin
      h_eff = DW'(1);
    end else if (DW'(height_in_use) > DW'(MAX_HEIGHT)) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = DW'(height_in_use);
    end
    wh = PW'(w_eff) * PW'(h_eff);
  end

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x,
                                            input logic [YW-1:0] y);
    return AW'(AW'(y) * AW'(MAX_WIDTH) + AW'(x));
  endfunction

  // Control and generation state.
  logic [AW-1:0]  clr_idx;
  logic           start_pend;
  logic [CW-1:0]  stack_count;
  logic [CW-1:0]  visited_count;
  logic [CW-1:0]  longest_seen;
  logic [XW-1:0]  end_x;
  logic [YW-1:0]  end_y;
  logic           running;
  logic [2:0]     nb_idx;

  // Working registers.
  logic [XW-1:0]  top_x;
  logic [YW-1:0]  top_y;
  logic [4:0]     top_bits;
  logic [3:0]     nb_vis;
  logic [4:0]     sx;
  logic [4:0]     sy;
  logic [14:0]    rnd;
  logic [XW-1:0]  fx;
  logic [YW-1:0]  fy;
  logic [1:0]     dir_q;
  logic [2:0]     res_action;
  logic [4:0]     res_x;
  logic [4:0]     res_y;
  logic [1:0]     res_dir;
  logic [4:0]     res_bits;

  logic done_now;
  assign done_now = (PW'(visited_count) >= wh);

  // Neighbor validity around the stack top.
  logic [3:0] nb_ok;
  assign nb_ok[0] = (top_y != '0);
  assign nb_ok[1] = (DW'(top_x) + DW'(1) < w_eff);
  assign nb_ok[2] = (DW'(top_y) + DW'(1) < h_eff);
  assign nb_ok[3] = (top_x != '0);

  mbg_pkg::pick_t pick;

  mbg_pick u_pick (
    .avail (nb_ok & ~nb_vis),
    .rnd   (rnd),
    .pick  (pick)
  );

  // Cell after a move in dir_q (in pick.dir during evaluation), and the wall bits on both sides.
  logic [XW-1:0] nc_x;
  logic [YW-1:0] nc_y;
  logic [4:0]    here_bit;
  logic [4:0]    there_bit;

  always_comb begin
    nc_x = top_x;
    nc_y = top_y;
    case (state == ST_EVAL ? pick.dir : dir_q)
      mbg_pkg::DIR_N: begin
        nc_y = top_y - YW'(1); here_bit = mbg_pkg::BIT_N; there_bit = mbg_pkg::BIT_S;
      end
      mbg_pkg::DIR_E: begin
        nc_x = top_x + XW'(1); here_bit = mbg_pkg::BIT_E; there_bit = mbg_pkg::BIT_W;
      end
      mbg_pkg::DIR_S: begin
        nc_y = top_y + YW'(1); here_bit = mbg_pkg::BIT_S; there_bit = mbg_pkg::BIT_N;
      end
      default: begin
        nc_x = top_x - XW'(1); here_bit = mbg_pkg::BIT_W; there_bit = mbg_pkg::BIT_E;
      end
    endcase
  end

  // Memories.
  logic                cell_we;
  logic [AW-1:0]       cell_waddr;
  logic [4:0]          cell_wdata;
  logic [AW-1:0]       cell_raddr;
  logic [4:0]          cell_rdata;
  logic                stk_we;
  logic [AW-1:0]       stk_waddr;
  logic [XW+YW-1:0]    stk_wdata;
  logic [AW-1:0]       stk_raddr;
  logic [XW+YW-1:0]    stk_rdata;

  mbg_ram #(.WIDTH(5), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  mbg_ram #(.WIDTH(XW + YW), .DEPTH(CELLS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  logic mod_done;
  assign mod_done = (DW'(sx) < w_eff) && (DW'(sy) < h_eff);

  // Memory port selection.
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = clr_idx;
    cell_wdata = '0;
    stk_we     = 1'b0;
    stk_waddr  = AW'(stack_count);
    stk_wdata  = {nc_y, nc_x};
    stk_raddr  = AW'(stack_count - CW'(2));
    cell_raddr = addr_of(top_x, top_y);
    case (state)
      ST_CLEAR: begin
        cell_we = 1'b1;
      end
      ST_MOD: begin
        cell_we    = mod_done;
        cell_waddr = addr_of(XW'(sx), YW'(sy));
        cell_wdata = mbg_pkg::BIT_VIS;
        stk_we     = mod_done;
        stk_waddr  = '0;
        stk_wdata  = {YW'(sy), XW'(sx)};
      end
      ST_NB: begin
        case (nb_idx)
          3'd1:    if (nb_ok[0]) cell_raddr = addr_of(top_x, top_y - YW'(1));
          3'd2:    if (nb_ok[1]) cell_raddr = addr_of(top_x + XW'(1), top_y);
          3'd3:    if (nb_ok[2]) cell_raddr = addr_of(top_x, top_y + YW'(1));
          3'd4:    if (nb_ok[3]) cell_raddr = addr_of(top_x - XW'(1), top_y);
          default: ;
        endcase
      end
      ST_EVAL: begin
        cell_we    = pick.found && (stack_count < CW'(CELLS));
        cell_waddr = addr_of(top_x, top_y);
        cell_wdata = top_bits | here_bit;
      end
      ST_CARVE: begin
        cell_we    = 1'b1;
        cell_waddr = addr_of(nc_x, nc_y);
        cell_wdata = mbg_pkg::BIT_VIS | there_bit;
        stk_we     = 1'b1;
      end
      ST_POP: begin
        cell_raddr = addr_of(stk_rdata[XW-1:0], stk_rdata[XW+YW-1:XW]);
      end
      ST_FETCH: begin
        cell_raddr = addr_of(fx, fy);
      end
      default: ;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      start_pend    <= 1'b0;
      stack_count   <= '0;
      visited_count <= '0;
      longest_seen  <= '0;
      end_x         <= '0;
      end_y         <= '0;
      running       <= 1'b0;
      nb_idx        <= '0;
      out_valid     <= 1'b0;
    end else begin
      // The output state refills the register itself when it frees up.
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= (clr_idx == AW'(CELLS - 1)) ? '0 : clr_idx + AW'(1);
          if (clr_idx == AW'(CELLS - 1)) begin
            state <= start_pend ? ST_MOD : ST_IDLE;
          end
        end
        ST_IDLE: begin
          res_dir <= mbg_pkg::DIR_N;
          rnd     <= in_word.rand_value;
          if (in_valid) begin
            case (in_word.mode)
              mbg_pkg::MODE_START: begin
                sx         <= in_word.coord_x;
                sy         <= in_word.coord_y;
                start_pend <= 1'b1;
                state      <= ST_CLEAR;
              end
              mbg_pkg::MODE_READ: begin
                res_action <= mbg_pkg::ACT_READ;
                res_x      <= in_word.coord_x;
                res_y      <= in_word.coord_y;
                fx         <= XW'(in_word.coord_x);
                fy         <= YW'(in_word.coord_y);
                res_bits   <= '0;
                if (DW'(in_word.coord_x) < w_eff && DW'(in_word.coord_y) < h_eff) begin
                  state <= ST_FETCH;
                end else begin
                  state <= ST_OUT;
                end
              end
              default: begin
                fx <= top_x;
                fy <= top_y;
                if (in_word.mode == mbg_pkg::MODE_STEP && running &&
                    !done_now && stack_count != '0) begin
                  nb_idx <= '0;
                  res_x  <= 5'(top_x);
                  res_y  <= 5'(top_y);
                  state  <= ST_NB;
                end else begin
                  if (in_word.mode == mbg_pkg::MODE_STEP && running) begin
                    running <= 1'b0;
                  end
                  res_action <= mbg_pkg::ACT_IDLE;
                  if (stack_count == '0) begin
                    res_x    <= '0;
                    res_y    <= '0;
                    res_bits <= '0;
                    state    <= ST_OUT;
                  end else begin
                    res_x <= 5'(top_x);
                    res_y <= 5'(top_y);
                    state <= ST_FETCH;
                  end
                end
              end
            endcase
          end
        end
        ST_MOD: begin
          // Fold the start cell into the grid by repeated subtraction.
          if (DW'(sx) >= w_eff) begin
            sx <= sx - w_eff[4:0];
          end else if (DW'(sy) >= h_eff) begin
            sy <= sy - h_eff[4:0];
          end else begin
            start_pend    <= 1'b0;
            top_x         <= XW'(sx);
            top_y         <= YW'(sy);
            stack_count   <= CW'(1);
            visited_count <= CW'(1);
            longest_seen  <= '0;
            end_x         <= '0;
            end_y         <= '0;
            running       <= 1'b1;
            res_action    <= mbg_pkg::ACT_STARTED;
            res_x         <= sx;
            res_y         <= sy;
            res_dir       <= mbg_pkg::DIR_N;
            res_bits      <= mbg_pkg::BIT_VIS;
            state         <= ST_OUT;
          end
        end
        ST_NB: begin
          // Read k is issued at index k, its data lands at index k+1.
          nb_idx <= nb_idx + 3'd1;
          case (nb_idx)
            3'd1:    top_bits  <= cell_rdata;
            3'd2:    nb_vis[0] <= cell_rdata[0];
            3'd3:    nb_vis[1] <= cell_rdata[0];
            3'd4:    nb_vis[2] <= cell_rdata[0];
            3'd5: begin
              nb_vis[3] <= cell_rdata[0];
              state     <= ST_EVAL;
            end
            default: ;
          endcase
        end
        ST_EVAL: begin
          if (pick.found && stack_count < CW'(CELLS)) begin
            dir_q <= pick.dir;
            state <= ST_CARVE;
          end else if (pick.found) begin
            res_action <= mbg_pkg::ACT_IDLE;
            res_bits   <= top_bits;
            state      <= ST_OUT;
          end else begin
            // Dead end: record the depth, then pop.
            if (stack_count > longest_seen) begin
              longest_seen <= stack_count;
              end_x        <= top_x;
              end_y        <= top_y;
            end
            stack_count <= stack_count - CW'(1);
            res_action  <= mbg_pkg::ACT_BACK;
            if (stack_count == CW'(1)) begin
              res_x    <= '0;
              res_y    <= '0;
              res_bits <= '0;
              state    <= ST_OUT;
            end else begin
              state <= ST_POP;
            end
          end
        end
        ST_CARVE: begin
          stack_count   <= stack_count + CW'(1);
          visited_count <= visited_count + CW'(1);
          top_x         <= nc_x;
          top_y         <= nc_y;
          res_action    <= mbg_pkg::ACT_CARVED;
          res_x         <= 5'(nc_x);
          res_y         <= 5'(nc_y);
          res_dir       <= dir_q;
          res_bits      <= mbg_pkg::BIT_VIS | there_bit;
          state         <= ST_OUT;
        end
        ST_POP: begin
          top_x <= stk_rdata[XW-1:0];
          top_y <= stk_rdata[XW+YW-1:XW];
          res_x <= 5'(stk_rdata[XW-1:0]);
          res_y <= 5'(stk_rdata[XW+YW-1:XW]);
          state <= ST_FETCH2;
        end
        ST_FETCH: begin
          state <= ST_FETCH2;
        end
        ST_FETCH2: begin
          res_bits <= cell_rdata;
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_word.action       <= res_action;
      out_word.pos_x        <= res_x;
      out_word.pos_y        <= res_y;
      out_word.direction    <= res_dir;
      out_word.cell_bits    <= res_bits;
      out_word.end_x        <= 5'(end_x);
      out_word.end_y        <= 5'(end_y);
      out_word.longest_path <= 11'(longest_seen);
      out_word.done_res     <= done_now;
    end
  end

  // One word in flight: nothing new is taken right after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted while one is in progress");

  // The second carve write always follows the first.
  a_carve_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CARVE) |-> $past(state == ST_EVAL))
    else $error("carve without neighbor evaluation");

  // Every stacked cell was visited.
  a_stack_visited: assert property (@(posedge clk) disable iff (rst)
    visited_count >= stack_count)
    else $error("stack deeper than visited count");

  // A result word comes only from the output state.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result word without a finished command");

endmodule
`default_nettype wire

// ===== hdl/mbg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/mbg_pick.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_pick
// Picks one open neighbor: entry (random mod count) of the open set, in
// north, east, south, west order.
// ----------------------------------------------------------------------------
module mbg_pick (
  input  wire logic [3:0]    avail,
  input  wire logic [14:0]   rnd,
  output mbg_pkg::pick_t     pick
);

  // Remainder by three through base-four digit sums.
  function automatic logic [1:0] mod3(input logic [14:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6])
      + 5'(v[9:8]) + 5'(v[11:10]) + 5'(v[13:12]) + 5'(v[14]);
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  logic [2:0] n;
  logic [1:0] k;
  logic [1:0] seen;
  logic [1:0] dir;

  // Index into the open set.
  always_comb begin
    n = 3'($countones(avail));
    case (n)
      3'd2:    k = {1'b0, rnd[0]};
      3'd3:    k = mod3(rnd);
      3'd4:    k = rnd[1:0];
      default: k = 2'd0;
    endcase
  end

  // Walk to the chosen set bit.
  always_comb begin
    seen = 2'd0;
    dir  = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (avail[i]) begin
        if (seen == k) begin
          dir = 2'(i);
        end
        seen = seen + 2'd1;
      end
    end
  end

  assign pick.found = (n != 3'd0);
  assign pick.dir   = dir;

endmodule
`default_nettype wire

// ===== bench/maze_backtracker_generator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_backtracker_generator_top_test
// Self-checking bench for the maze generator: a directed table of commands
// followed by randomized maze runs on many grid sizes. Every result word is
// checked against a typed table word or against a behavioral maze model that
// carves its own copy of the grid and coordinate stack.
// ----------------------------------------------------------------------------
module maze_backtracker_generator_top_test;
  import mbg_pkg::*;

  localparam int GRID_W      = MAX_WIDTH_DEF;
  localparam int GRID_H      = MAX_HEIGHT_DEF;
  localparam int CELL_COUNT  = GRID_W * GRID_H;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 30;
  localparam int ITEM_GOAL   = 1050;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_word;
  logic out_valid;
  logic out_ready;
  out_t out_word;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  maze_backtracker_generator_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Model state of the maze.
  logic [5:0] size_w_reg;
  logic [5:0] size_h_reg;
  logic [4:0] grid_cells [CELL_COUNT];
  int         path_cells [CELL_COUNT];
  int         depth;
  int         visited;
  int         longest;
  int         end_idx;
  bit         carving;

  out_t expected_results [$];
  int   errors;
  int   items_sent;
  int   cycles;

  // Directed table row: a command, optional size change before it, and an
  // expected word where it is obvious.
  typedef struct {
    bit         set_size;
    logic [5:0] new_w;
    logic [5:0] new_h;
    in_t        cmd;
    bit         typed;
    out_t       want;
  } table_row_t;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int clamp_w();
    int v;
    v = size_w_reg;
    if (v < 1) v = 1;
    if (v > GRID_W) v = GRID_W;
    return v;
  endfunction

  function automatic int clamp_h();
    int v;
    v = size_h_reg;
    if (v < 1) v = 1;
    if (v > GRID_H) v = GRID_H;
    return v;
  endfunction

  function automatic out_t make_word(logic [2:0] act, int x, int y, logic [1:0] dir,
                                     logic [4:0] bits);
    out_t r;
    r.action       = act;
    r.pos_x        = x[4:0];
    r.pos_y        = y[4:0];
    r.direction    = dir;
    r.cell_bits    = bits;
    r.end_x        = 5'(end_idx % GRID_W);
    r.end_y        = 5'(end_idx / GRID_W);
    r.longest_path = longest[10:0];
    r.done_res     = (visited >= clamp_w() * clamp_h());
    return r;
  endfunction

  function automatic out_t top_word(logic [2:0] act, logic [1:0] dir);
    int c;
    if (depth == 0) return make_word(act, 0, 0, dir, 5'd0);
    c = path_cells[depth-1];
    return make_word(act, c % GRID_W, c / GRID_W, dir, grid_cells[c]);
  endfunction

  // Applies one command to the model maze and returns the expected word.
  function automatic out_t maze_predict(in_t cmd);
    int w, h, sx, sy, c, x, y, n, nc;
    logic [1:0] opts [4];
    logic [1:0] dir;
    logic [4:0] here, there;
    w = clamp_w();
    h = clamp_h();
    if (cmd.mode == MODE_START) begin
      sx = int'(cmd.coord_x) % w;
      sy = int'(cmd.coord_y) % h;
      c = sy * GRID_W + sx;
      foreach (grid_cells[i]) grid_cells[i] = 5'd0;
      grid_cells[c] = BIT_VIS;
      path_cells[0] = c;
      depth = 1;
      visited = 1;
      longest = 0;
      end_idx = 0;
      carving = 1'b1;
      return make_word(ACT_STARTED, sx, sy, DIR_N, BIT_VIS);
    end
    if (cmd.mode == MODE_READ) begin
      here = 5'd0;
      if (int'(cmd.coord_x) < w && int'(cmd.coord_y) < h)
        here = grid_cells[int'(cmd.coord_y) * GRID_W + int'(cmd.coord_x)];
      return make_word(ACT_READ, int'(cmd.coord_x), int'(cmd.coord_y), DIR_N, here);
    end
    if (cmd.mode == MODE_IDLE || !carving) return top_word(ACT_IDLE, DIR_N);
    if (visited >= w * h || depth == 0) begin
      carving = 1'b0;
      return top_word(ACT_IDLE, DIR_N);
    end
    c = path_cells[depth-1];
    x = c % GRID_W;
    y = c / GRID_W;
    n = 0;
    // Unvisited neighbors in north, east, south, west order.
    if (y > 0 && !grid_cells[c-GRID_W][0]) begin opts[n] = DIR_N; n++; end
    if (x + 1 < w && !grid_cells[c+1][0]) begin opts[n] = DIR_E; n++; end
    if (y + 1 < h && !grid_cells[c+GRID_W][0]) begin opts[n] = DIR_S; n++; end
    if (x > 0 && !grid_cells[c-1][0]) begin opts[n] = DIR_W; n++; end
    if (n > 0 && depth < CELL_COUNT) begin
      dir = opts[int'(cmd.rand_value) % n];
      case (dir)
        DIR_N: begin nc = c - GRID_W; here = BIT_N; there = BIT_S; end
        DIR_E: begin nc = c + 1; here = BIT_E; there = BIT_W; end
        DIR_S: begin nc = c + GRID_W; here = BIT_S; there = BIT_N; end
        default: begin nc = c - 1; here = BIT_W; there = BIT_E; end
      endcase
      grid_cells[c] = grid_cells[c] | here;
      grid_cells[nc] = grid_cells[nc] | BIT_VIS | there;
      path_cells[depth] = nc;
      depth++;
      visited++;
      return top_word(ACT_CARVED, dir);
    end
    if (n > 0) return top_word(ACT_IDLE, DIR_N);
    // Dead end: remember the deepest one, then back up.
    if (depth > longest) begin
      longest = depth;
      end_idx = c;
    end
    depth--;
    return top_word(ACT_BACK, DIR_N);
  endfunction

  task automatic report(string field, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  // Result side: random stalls, and every accepted word checked in order.
  initial begin : result_side
    int stall;
    out_t want;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected word", int'(out_word.action), 0);
        end else begin
          want = expected_results.pop_front();
          if (out_word.action != want.action)
            report("action", int'(out_word.action), int'(want.action));
          if (out_word.pos_x != want.pos_x)
            report("pos_x", int'(out_word.pos_x), int'(want.pos_x));
          if (out_word.pos_y != want.pos_y)
            report("pos_y", int'(out_word.pos_y), int'(want.pos_y));
          if (out_word.direction != want.direction)
            report("direction", int'(out_word.direction), int'(want.direction));
          if (out_word.cell_bits != want.cell_bits)
            report("cell_bits", int'(out_word.cell_bits), int'(want.cell_bits));
          if (out_word.end_x != want.end_x)
            report("end_x", int'(out_word.end_x), int'(want.end_x));
          if (out_word.end_y != want.end_y)
            report("end_y", int'(out_word.end_y), int'(want.end_y));
          if (out_word.longest_path != want.longest_path)
            report("longest_path", int'(out_word.longest_path), int'(want.longest_path));
          if (out_word.done_res != want.done_res)
            report("done_res", int'(out_word.done_res), int'(want.done_res));
        end
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (stall > 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        if (stall > 0) stall--;
        if (stall == 0) out_ready <= 1'b1;
      end
    end
  end

  // Sends one command word, records its expected result, then at times idles for a random gap.
  task automatic send_word(in_t cmd, bit typed, out_t want);
    int gap;
    out_t pred;
    in_valid <= 1'b1;
    in_word  <= cmd;
    do @(posedge clk); while (!in_ready);
    pred = maze_predict(cmd);
    expected_results = {expected_results, (typed ? want : pred)};
    items_sent++;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits for the block to go quiet, then changes the grid size.
  task automatic set_size(logic [5:0] w, logic [5:0] h);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_w_reg = w;
    size_h_reg = h;
  endtask

  function automatic in_t cmd_of(logic [1:0] m, int x, int y, int r);
    in_t c;
    c.mode = m;
    c.coord_x = x[4:0];
    c.coord_y = y[4:0];
    c.rand_value = r[14:0];
    return c;
  endfunction

  function automatic out_t typed_word(logic [2:0] act, int x, int y, logic [4:0] bits,
                                      bit done);
    out_t r;
    r = '0;
    r.action = act;
    r.pos_x = x[4:0];
    r.pos_y = y[4:0];
    r.cell_bits = bits;
    r.done_res = done;
    return r;
  endfunction

  // Stimulus.
  initial begin : command_side
    table_row_t rows [$];
    table_row_t row;
    out_t none;
    int w, h, steps, pick;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_wdata = '0;
    errors = 0;
    items_sent = 0;
    cycles = 0;
    size_w_reg = SIZE_RESET;
    size_h_reg = SIZE_RESET;
    foreach (grid_cells[i]) grid_cells[i] = 5'd0;
    depth = 0; visited = 0; longest = 0; end_idx = 0; carving = 1'b0;
    none = '0;

    // Directed table: after reset, extremes of sizes and coordinates, all modes.
    row = '{0, 0, 0, cmd_of(MODE_READ, 0, 0, 0), 1, typed_word(ACT_READ, 0, 0, 0, 0)};
    rows = {rows, row};
    row = '{0, 0, 0, cmd_of(MODE_STEP, 31, 31, 32767), 1, typed_word(ACT_IDLE, 0, 0, 0, 0)};
    rows = {rows, row};
    row = '{0, 0, 0, cmd_of(MODE_IDLE, 31, 31, 32767), 1, typed_word(ACT_IDLE, 0, 0, 0, 0)};
    rows = {rows, row};
    row = '{0, 0, 0, cmd_of(MODE_START, 31, 31, 0), 1,
            typed_word(ACT_STARTED, 31, 31, BIT_VIS, 0)};
    rows = {rows, row};
    for (int i = 0; i < 4; i++) begin
      row = '{0, 0, 0, cmd_of(MODE_STEP, 0, 0, i * 8191), 0, none};
      rows = {rows, row};
    end
    row = '{0, 0, 0, cmd_of(MODE_READ, 31, 31, 0), 0, none};
    rows = {rows, row};
    row = '{0, 0, 0, cmd_of(MODE_IDLE, 0, 0, 0), 0, none};
    rows = {rows, row};
    // Zero size counts as one cell: a start completes the maze at once.
    row = '{1, 6'd0, 6'd0, cmd_of(MODE_START, 5, 7, 0), 1,
            typed_word(ACT_STARTED, 0, 0, BIT_VIS, 1)};
    rows = {rows, row};
    row = '{0, 0, 0, cmd_of(MODE_STEP, 0, 0, 1), 0, none};
    rows = {rows, row};
    row = '{0, 0, 0, cmd_of(MODE_STEP, 0, 0, 2), 0, none};
    rows = {rows, row};
    // Start outside a small grid wraps; reads outside the grid give no bits.
    row = '{1, 6'd2, 6'd3, cmd_of(MODE_START, 7, 9, 0), 0, none};
    rows = {rows, row};
    for (int i = 0; i < 4; i++) begin
      row = '{0, 0, 0, cmd_of(MODE_STEP, 0, 0, 32767 - i), 0, none};
      rows = {rows, row};
    end
    row = '{0, 0, 0, cmd_of(MODE_READ, 31, 0, 0), 1, none};
    row.want = typed_word(ACT_READ, 31, 0, 0, 0);
    row.typed = 0;
    rows = {rows, row};
    // Oversized registers clamp to the full grid.
    row = '{1, 6'd63, 6'd63, cmd_of(MODE_START, 0, 0, 0), 1,
            typed_word(ACT_STARTED, 0, 0, BIT_VIS, 0)};
    rows = {rows, row};
    row = '{0, 0, 0, cmd_of(MODE_STEP, 0, 0, 21845), 0, none};
    rows = {rows, row};
    row = '{0, 0, 0, cmd_of(MODE_READ, 31, 31, 10922), 0, none};
    rows = {rows, row};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].set_size) set_size(rows[i].new_w, rows[i].new_h);
      send_word(rows[i].cmd, rows[i].typed, rows[i].want);
    end

    // Random maze runs: mostly well-formed carving with some noise mixed in.
    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        w = $urandom_range(0, 63);
        h = $urandom_range(0, 63);
      end else if (pick < 4) begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
      end
      set_size(6'(w), 6'(h));
      send_word(cmd_of(MODE_START, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 32767)), 0, none);
      w = clamp_w();
      h = clamp_h();
      steps = 2 * w * h + 2;
      if (steps > 80) steps = 80;
      for (int s = 0; s < steps; s++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          send_word(cmd_of(MODE_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 32767)), 0, none);
        else if (pick < 11)
          send_word(cmd_of(MODE_IDLE, $urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 32767)), 0, none);
        else if (pick < 12)
          send_word(cmd_of(MODE_START, $urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 32767)), 0, none);
        else if (pick < 20)
          send_word(cmd_of(MODE_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                           $urandom_range(0, 32767)), 0, none);
        else
          send_word(cmd_of(MODE_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 32767)), 0, none);
      end
    end

    // Drain and settle.
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mbg_pkg.sv
hdl/mbg_ram.sv
hdl/mbg_pick.sv
hdl/maze_backtracker_generator_top.sv
bench/maze_backtracker_generator_top_test.sv
